// File: rtl/core/tfd_pkg.sv
// Shared types and constants for the tunnel frame deframer.
package tfd_pkg;

   // Largest payload accepted before a frame is flagged as oversize.
   localparam int unsigned MAX_PAYLOAD = 1472;

   localparam logic [7:0] HEARTBEAT = 8'd0;

   // Header bytes after the type byte: 4 address, 2 port, 2 length.
   localparam int unsigned HDR_BYTES = 8;
   localparam int unsigned HDR_CNT_W = $clog2(HDR_BYTES);

   // Register map, word index into the configuration space.
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0]  CSR_USE_FRAME_DST = 2'd0;
   localparam logic [1:0]  CSR_FIXED_DST_IP  = 2'd1;
   localparam logic [1:0]  CSR_FIXED_DST_PORT = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_SKIP    = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      K_DATA      = 2'd0,
      K_HEARTBEAT = 2'd1,
      K_EMPTY     = 2'd2,
      K_OVERSIZE  = 2'd3
   } kind_type;

endpackage

// File: rtl/core/tunnel_frame_deframer_top.sv
// Tunnel frame deframer: byte stream in, datagram bytes and frame events out.
//
// Usage
//  - req_* channel: one stream byte per transfer (req_valid high, req_stall low).
//  - rsp_* channel: at most one result per input byte - a payload byte with its
//    destination, a heartbeat, an empty-datagram mark or an oversize error.
//    rsp_last marks the final result of a frame.
//  - APB-style port (psel/penable/...): destination mode at 0x0, fixed
//    address at 0x4, fixed port at 0x8. Write only while the block is idle.
//  - A result is registered; it appears in the cycle after its byte is taken.
//  - Throughput: one byte per cycle while the receiver does not stall, set by
//    the single result register; the parser state updates in the same cycle as the transfer.
//  - When the receiver stalls a valid result, the result register holds it and
//    req_stall rises in the same cycle; no byte is taken until it drains.
//  - Reset (synchronous, active high) returns the parser to waiting for a
//    type byte, clears the frame fields, the configuration registers and rsp_valid.
//  - Oversize frames report one error result and their payload is swallowed.
module tunnel_frame_deframer_top (
   input  logic                              clock,
   input  logic                              reset,
   // input stream
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_rx_byte,
   // results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_kind,
   output logic [7:0]                        rsp_payload_byte,
   output logic [31:0]                       rsp_dst_ip,
   output logic [15:0]                       rsp_dst_port,
   output logic [15:0]                       rsp_datagram_length,
   output logic                              rsp_last,
   // configuration
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [tfd_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import tfd_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic        use_frame_dst_ff;
   logic [31:0] fixed_ip_ff;
   logic [15:0] fixed_port_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_idx = paddr[3:2];
   assign csr_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_frame_dst_ff <= 1'b0;
         fixed_ip_ff      <= '0;
         fixed_port_ff    <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_USE_FRAME_DST:  use_frame_dst_ff <= pwdata[0];
            CSR_FIXED_DST_IP:   fixed_ip_ff      <= pwdata;
            CSR_FIXED_DST_PORT: fixed_port_ff    <= pwdata[15:0];
            default: ;          // unmapped word, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_USE_FRAME_DST:  prdata = {31'd0, use_frame_dst_ff};
         CSR_FIXED_DST_IP:   prdata = fixed_ip_ff;
         CSR_FIXED_DST_PORT: prdata = {16'd0, fixed_port_ff};
         default:            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------
   phase_type              phase_ff,     phase_in;
   logic [HDR_CNT_W-1:0]   hdr_cnt_ff,   hdr_cnt_in;
   logic [31:0]            frame_ip_ff,  frame_ip_in;
   logic [15:0]            frame_port_ff, frame_port_in;
   logic [15:0]            frame_len_ff, frame_len_in;
   logic [15:0]            bytes_left_ff, bytes_left_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    kind_ff,      kind_in;
   logic [7:0]  byte_ff,      byte_in;
   logic [31:0] ip_ff,        ip_in;
   logic [15:0] port_ff,      port_in;
   logic [15:0] len_ff,       len_in;
   logic        last_ff,      last_in;

   logic        advance;   // result register free to take a new value
   logic        take;      // input transfer this cycle
   logic        emit;
   logic        with_dst;
   logic [15:0] left_dec;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign take      = req_valid && advance;
   assign left_dec  = bytes_left_ff - 16'd1;

   always_comb begin
      phase_in      = phase_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      frame_ip_in   = frame_ip_ff;
      frame_port_in = frame_port_ff;
      frame_len_in  = frame_len_ff;
      bytes_left_in = bytes_left_ff;
      emit          = 1'b0;
      with_dst      = 1'b0;
      kind_in       = K_DATA;
      byte_in       = 8'd0;
      last_in       = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_rx_byte == HEARTBEAT) begin
               emit    = 1'b1;
               kind_in = K_HEARTBEAT;
               last_in = 1'b1;
            end else begin
               phase_in   = PH_HEADER;
               hdr_cnt_in = '0;
            end
         end
         PH_HEADER: begin
            // address big-endian, port and length little-endian
            case (hdr_cnt_ff)
               3'd4:    frame_port_in = {frame_port_ff[15:8], req_rx_byte};
               3'd5:    frame_port_in = {req_rx_byte, frame_port_ff[7:0]};
               3'd6:    frame_len_in  = {frame_len_ff[15:8], req_rx_byte};
               3'd7:    frame_len_in  = {req_rx_byte, frame_len_ff[7:0]};
               default: frame_ip_in   = {frame_ip_ff[23:0], req_rx_byte};
            endcase
            hdr_cnt_in = hdr_cnt_ff + 1'b1;
            if (hdr_cnt_ff == HDR_CNT_W'(HDR_BYTES - 1)) begin
               hdr_cnt_in    = '0;
               bytes_left_in = frame_len_in;
               if (frame_len_in == 16'd0) begin
                  phase_in = PH_IDLE;
                  emit     = 1'b1;
                  with_dst = 1'b1;
                  kind_in  = K_EMPTY;
                  last_in  = 1'b1;
               end else if (frame_len_in > 16'(MAX_PAYLOAD)) begin
                  phase_in = PH_SKIP;
                  emit     = 1'b1;
                  with_dst = 1'b1;
                  kind_in  = K_OVERSIZE;
                  last_in  = 1'b1;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            bytes_left_in = left_dec;
            if (left_dec == 16'd0) phase_in = PH_IDLE;
            emit     = 1'b1;
            with_dst = 1'b1;
            kind_in  = K_DATA;
            byte_in  = req_rx_byte;
            last_in  = (left_dec == 16'd0);
         end
         PH_SKIP: begin
            bytes_left_in = left_dec;
            if (left_dec == 16'd0) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase

      // destination follows the mode register at the time of the result
      ip_in   = 32'd0;
      port_in = 16'd0;
      len_in  = 16'd0;
      if (with_dst) begin
         ip_in   = use_frame_dst_ff ? frame_ip_ff   : fixed_ip_ff;
         port_in = use_frame_dst_ff ? frame_port_ff : fixed_port_ff;
         len_in  = frame_len_in;
      end

      rsp_valid_in = advance ? (take && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hdr_cnt_ff    <= '0;
         frame_ip_ff   <= '0;
         frame_port_ff <= '0;
         frame_len_ff  <= '0;
         bytes_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff      <= phase_in;
            hdr_cnt_ff    <= hdr_cnt_in;
            frame_ip_ff   <= frame_ip_in;
            frame_port_ff <= frame_port_in;
            frame_len_ff  <= frame_len_in;
            bytes_left_ff <= bytes_left_in;
         end
      end
   end

   // payload of the result register: loaded only on a transfer with a result
   always_ff @(posedge clock) begin
      if (take && emit) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         ip_ff   <= ip_in;
         port_ff <= port_in;
         len_ff  <= len_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = kind_ff;
   assign rsp_payload_byte    = byte_ff;
   assign rsp_dst_ip          = ip_ff;
   assign rsp_dst_port        = port_ff;
   assign rsp_datagram_length = len_ff;
   assign rsp_last            = last_ff;

endmodule

// File: verif/tb.sv
// Self-checking testbench for the tunnel frame deframer top level.
`timescale 1ns / 1ps

module tb;
   import tfd_pkg::*;

   localparam int unsigned RANDOM_ITEMS   = 450;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   // Address 0xC holds no register; writes to it must leave the map untouched.
   localparam logic [1:0]  CSR_UNMAPPED   = 2'd3;

   // One result transfer, laid out in port order.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [31:0] ip;
      logic [15:0] port;
      logic [15:0] len;
      logic        last;
   } deframed_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [31:0] rsp_dst_ip;
   logic [15:0] rsp_dst_port;
   logic [15:0] rsp_datagram_length;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // Mirror of the register map
   logic        mode_frame_dst = 1'b0;
   logic [31:0] fixed_ip = 32'h0;
   logic [15:0] fixed_port = 16'h0;

   // Mirror of the parser state
   phase_type   parse_phase = PH_IDLE;
   logic [3:0]  hdr_idx = 4'd0;
   logic [31:0] hdr_ip = 32'h0;
   logic [15:0] hdr_port = 16'h0;
   logic [15:0] hdr_len = 16'h0;
   logic [15:0] bytes_to_go = 16'h0;

   deframed_type deframed_q[$];
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   bit          no_idle = 1'b0;

   tunnel_frame_deframer_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_payload_byte(rsp_payload_byte), .rsp_dst_ip(rsp_dst_ip),
      .rsp_dst_port(rsp_dst_port), .rsp_datagram_length(rsp_datagram_length),
      .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Wait drawn per transfer; zero throughout a no-idle stretch.
   function automatic int unsigned draw_wait();
      return no_idle ? 0 : $urandom_range(0, 15);
   endfunction

   // Zero, all ones or anything: keeps register extremes turning up.
   function automatic logic [31:0] corner_value();
      case ($urandom_range(0, 3))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Parser mirror: advances on one accepted stream byte and queues the
   // result that byte gives, if any. Destination is taken from the
   // registers as they stand now, so a mid-frame write counts at once.
   function automatic void deframe_byte(input logic [7:0] b);
      deframed_type r;
      bit           gives, with_dst;
      r = '0;
      gives = 1'b0;
      with_dst = 1'b0;
      case (parse_phase)
         PH_IDLE:
            if (b == HEARTBEAT) begin
               r.kind = K_HEARTBEAT;
               r.last = 1'b1;
               gives = 1'b1;
            end else begin
               parse_phase = PH_HEADER;
               hdr_idx = 4'd0;
            end
         PH_HEADER: begin
            case (hdr_idx)
               4'd0, 4'd1, 4'd2, 4'd3: hdr_ip = {hdr_ip[23:0], b};
               4'd4: hdr_port[7:0] = b;
               4'd5: hdr_port[15:8] = b;
               4'd6: hdr_len[7:0] = b;
               default: hdr_len[15:8] = b;
            endcase
            hdr_idx = hdr_idx + 4'd1;
            if (hdr_idx == HDR_BYTES) begin
               hdr_idx = 4'd0;
               bytes_to_go = hdr_len;
               if (hdr_len == 16'd0) begin
                  parse_phase = PH_IDLE;
                  r.kind = K_EMPTY;
                  r.last = 1'b1;
                  gives = 1'b1;
                  with_dst = 1'b1;
               end else if (hdr_len > MAX_PAYLOAD) begin
                  parse_phase = PH_SKIP;
                  r.kind = K_OVERSIZE;
                  r.last = 1'b1;
                  gives = 1'b1;
                  with_dst = 1'b1;
               end else begin
                  parse_phase = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            bytes_to_go = bytes_to_go - 16'd1;
            if (bytes_to_go == 16'd0) parse_phase = PH_IDLE;
            r.kind = K_DATA;
            r.data = b;
            r.last = (bytes_to_go == 16'd0);
            gives = 1'b1;
            with_dst = 1'b1;
         end
         default: begin
            // oversize payload is swallowed without a result
            bytes_to_go = bytes_to_go - 16'd1;
            if (bytes_to_go == 16'd0) parse_phase = PH_IDLE;
         end
      endcase
      if (with_dst) begin
         r.ip = mode_frame_dst ? hdr_ip : fixed_ip;
         r.port = mode_frame_dst ? hdr_port : fixed_port;
         r.len = hdr_len;
      end
      if (gives) deframed_q.push_back(r);
   endfunction

   // One stream byte: optional gap, then hold valid until the transfer.
   // Entered and left just after a rising edge, so valid is written once
   // per time step.
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      deframe_byte(b);
   endtask

   // Type byte plus the eight header bytes: address MSB first, port and
   // length little-endian.
   task automatic send_header(input logic [7:0] kind_b, input logic [31:0] ip,
                              input logic [15:0] port, input logic [15:0] len);
      send_byte(kind_b);
      send_byte(ip[31:24]);
      send_byte(ip[23:16]);
      send_byte(ip[15:8]);
      send_byte(ip[7:0]);
      send_byte(port[7:0]);
      send_byte(port[15:8]);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
   endtask

   task automatic send_random_bytes(input int unsigned n);
      repeat (n) send_byte(8'($urandom));
   endtask

   // Quiesce: stop sending, let every expected result drain, then allow a
   // few cycles for a skipped tail that gives no result.
   task automatic drain();
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, access cycle, then the port is deselected before the task returns.
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         CSR_USE_FRAME_DST:  mode_frame_dst = val[0];
         CSR_FIXED_DST_IP:   fixed_ip = val;
         CSR_FIXED_DST_PORT: fixed_port = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // ---- tests ---------------------------------------------------------

   // Zero type bytes straight after reset: one heartbeat each.
   task automatic test_heartbeat();
      repeat (3) send_byte(HEARTBEAT);
   endtask

   // Destination from the fixed registers, upper write bits to be dropped.
   task automatic test_fixed_destination();
      drain();
      csr_write(CSR_USE_FRAME_DST, 32'hFFFF_FFFE);
      csr_write(CSR_FIXED_DST_IP, 32'hFFFF_FFFF);
      csr_write(CSR_FIXED_DST_PORT, 32'hFFFF_FFFF);
      send_header(8'hFF, 32'h8000_0001, 16'h8001, 16'd2);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_header(8'h01, 32'h0, 16'h0, 16'd1);
      send_byte(8'h80);
   endtask

   // Destination from the header; empty datagram with all-ones address and port.
   task automatic test_frame_destination();
      drain();
      csr_write(CSR_USE_FRAME_DST, 32'h1);
      send_header(8'h7F, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
      send_header(8'h01, 32'h0102_0304, 16'h1234, 16'd3);
      send_byte(8'h55);
      send_byte(8'hAA);
      send_byte(8'h01);
   endtask

   // Register change halfway through a payload, plus a write to the hole.
   task automatic test_mid_frame_config();
      send_header(8'h02, 32'hC0A8_0001, 16'h1F90, 16'd4);
      send_random_bytes(2);
      drain();
      csr_write(CSR_USE_FRAME_DST, 32'h0);
      csr_write(CSR_FIXED_DST_IP, 32'h0A00_0001);
      csr_write(CSR_FIXED_DST_PORT, 32'h0000_0035);
      csr_write(CSR_UNMAPPED, $urandom);
      send_random_bytes(2);
   endtask

   // One past the largest legal length: one error result, the whole
   // payload swallowed, then a heartbeat shows the parser back at idle.
   task automatic test_length_limits();
      drain();
      csr_write(CSR_USE_FRAME_DST, 32'h1);
      send_header(8'h22, $urandom, 16'($urandom), 16'(MAX_PAYLOAD + 1));
      send_random_bytes(MAX_PAYLOAD + 1);
      send_byte(HEARTBEAT);
   endtask

   // Well-formed frames with random content, chosen from the parser state.
   // Now and then a longer length up to 511. Registers and the idling
   // pattern change at frame boundaries.
   task automatic test_random_stream();
      int unsigned counted, since_cfg, r;
      logic [15:0] plan_len;
      logic [7:0]  b;
      counted = 0;
      since_cfg = 0;
      plan_len = 16'd0;
      while (counted < RANDOM_ITEMS || parse_phase != PH_IDLE) begin
         if (parse_phase == PH_IDLE && since_cfg >= 100) begin
            drain();
            csr_write(CSR_USE_FRAME_DST, $urandom);
            csr_write(CSR_FIXED_DST_IP, corner_value());
            csr_write(CSR_FIXED_DST_PORT, corner_value());
            no_idle = ($urandom_range(0, 3) == 0);
            since_cfg = 0;
         end
         case (parse_phase)
            PH_IDLE:
               b = ($urandom_range(0, 6) == 0) ? HEARTBEAT : 8'($urandom_range(1, 255));
            PH_HEADER:
               if (hdr_idx == 4'd6) begin
                  r = $urandom_range(0, 99);
                  if (r < 8)       plan_len = 16'd0;
                  else if (r < 80) plan_len = 16'($urandom_range(1, 16));
                  else if (r < 94) plan_len = 16'($urandom_range(17, 64));
                  else if (r < 97) plan_len = 16'($urandom_range(65, 255));
                  else             plan_len = 16'($urandom_range(256, 511));
                  b = plan_len[7:0];
               end else if (hdr_idx == 4'd7) begin
                  b = plan_len[15:8];
               end else begin
                  b = 8'($urandom);
               end
            default:
               b = 8'($urandom);
         endcase
         if (parse_phase != PH_SKIP) begin
            counted++;
            since_cfg++;
         end
         send_byte(b);
      end
      no_idle = 1'b0;
   endtask

   // Largest legal length: no error result, payload bytes carry it. Last
   // test, so the frame is left open after a few bytes.
   task automatic test_largest_legal_length();
      send_header(8'h11, $urandom, 16'($urandom), 16'(MAX_PAYLOAD));
      send_random_bytes(4);
   endtask

   // ---- result checking ----------------------------------------------

   // Receiver stall: after each result transfer, stall for a drawn count.
   always @(posedge clock) begin
      int unsigned n;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         n = draw_wait();
         stall_left <= n;
         rsp_stall <= (n != 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= (stall_left > 1);
      end
   end

   // Every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      deframed_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_kind, rsp_payload_byte, rsp_dst_ip, rsp_dst_port,
                rsp_datagram_length, rsp_last};
         if (deframed_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected kind=%0d byte=%02h ip=%08h port=%04h len=%0d last=%0b",
                     $time, got.kind, got.data, got.ip, got.port, got.len, got.last);
         end else begin
            want = deframed_q.pop_front();
            if (got !== want) begin
               fail_count++;
               $display("%0t: expected kind=%0d byte=%02h ip=%08h port=%04h len=%0d last=%0b",
                        $time, want.kind, want.data, want.ip, want.port, want.len,
                        want.last);
               $display("%0t: actual   kind=%0d byte=%02h ip=%08h port=%04h len=%0d last=%0b",
                        $time, got.kind, got.data, got.ip, got.port, got.len,
                        got.last);
            end
         end
      end
   end

   // Watchdog: too long without any transfer on any port ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_heartbeat();
      test_fixed_destination();
      test_frame_destination();
      test_mid_frame_config();
      test_length_limits();
      test_random_stream();
      test_largest_legal_length();
      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && deframed_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/tfd_pkg.sv
rtl/core/tunnel_frame_deframer_top.sv
verif/tb.sv
